>>> design/u8sg_pkg.sv
`default_nettype none

package u8sg_pkg;

    // Pending-sequence code: what the next continuation octet must be
    typedef enum logic [3:0] {
        EXP_NONE   = 4'd0,
        EXP_2OF2   = 4'd2,
        EXP_E0     = 4'd3,
        EXP_ED     = 4'd4,
        EXP_3B     = 4'd5,
        EXP_3OF3   = 4'd6,
        EXP_F0     = 4'd7,
        EXP_F4     = 4'd8,
        EXP_4B     = 4'd9,
        EXP_3OF4   = 4'd10,
        EXP_4OF4   = 4'd11
    } exp_t;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_SEP   = 2'd1,
        KIND_POINT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FORM_RAW   = 2'd0,
        FORM_ASCII = 2'd1,
        FORM_CP    = 2'd2
    } form_t;

    localparam logic [15:0] TOKEN_END     = 16'd1;
    localparam logic [15:0] TOKEN_OCT_MIN = 16'd2;
    localparam logic [15:0] TOKEN_OCT_MAX = 16'd257;
    localparam logic [20:0] SEP_TOKEN     = 21'd258;
    localparam logic [20:0] MAX_CP        = 21'h10FFFF;
    localparam logic [1:0]  FORM_RESET    = FORM_ASCII;

endpackage

`default_nettype wire

>>> design/utf8_sequence_grouper.sv
// An item's first result is offered in the cycle after the item is accepted.
// Results leave at one per cycle while out_stall is low; an item producing N results (0 to 8)
//   holds the input until its last result is taken.
// The result burst register is reloaded in the same cycle its last result is taken.
// Reset (rst_n low, asynchronous): no pending sequence, output empty, form_reg = 1 (FORM_ASCII).
`default_nettype none

module utf8_sequence_grouper
    import u8sg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] token,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [20:0]      value,
    output logic [2:0]       byte_count,
    output logic             last
);

    logic [1:0]  form_reg;
    exp_t        exp_reg, exp_next;
    logic [23:0] held_reg, held_next;

    // Burst description: octets (optionally each followed by a separator), then a tail
    // of up to two entries, the second of which is always a separator.
    logic        busy_reg;
    logic [2:0]  idx_reg;
    logic [31:0] b_oct_reg, b_oct_next;
    logic [2:0]  b_cnt_reg, b_cnt_next;
    logic        b_sep_reg, b_sep_next;
    logic [3:0]  b_flen_reg, b_flen_next;
    logic [1:0]  b_kind_reg, b_kind_next;
    logic [20:0] b_val_reg, b_val_next;
    logic [2:0]  b_bytes_reg, b_bytes_next;
    logic [3:0]  b_total_reg, b_total_next;
    logic [1:0]  tcnt_next;

    logic        in_fire, out_fire, is_last;
    logic        is_oct, raw, cont_ok;
    logic [15:0] tok_m2;
    logic [7:0]  oc;
    logic [1:0]  held_cnt;
    logic [7:0]  lo, hi;
    exp_t        nxt, lead;
    logic [20:0] cp;

    assign tok_m2 = token - TOKEN_OCT_MIN;
    assign oc     = tok_m2[7:0];
    assign is_oct = (token >= TOKEN_OCT_MIN) && (token <= TOKEN_OCT_MAX);
    assign raw    = (form_reg == FORM_RAW);

    always_comb
    begin
        held_cnt = 2'd0;
        lo       = 8'h80;
        hi       = 8'hBF;
        nxt      = EXP_NONE;
        case (exp_reg)
            EXP_2OF2: held_cnt = 2'd1;
            EXP_E0:
            begin
                held_cnt = 2'd1;
                lo       = 8'hA0;
                nxt      = EXP_3OF3;
            end
            EXP_ED:
            begin
                held_cnt = 2'd1;
                hi       = 8'h9F;
                nxt      = EXP_3OF3;
            end
            EXP_3B:
            begin
                held_cnt = 2'd1;
                nxt      = EXP_3OF3;
            end
            EXP_3OF3: held_cnt = 2'd2;
            EXP_F0:
            begin
                held_cnt = 2'd1;
                lo       = 8'h90;
                nxt      = EXP_3OF4;
            end
            EXP_F4:
            begin
                held_cnt = 2'd1;
                hi       = 8'h8F;
                nxt      = EXP_3OF4;
            end
            EXP_4B:
            begin
                held_cnt = 2'd1;
                nxt      = EXP_3OF4;
            end
            EXP_3OF4:
            begin
                held_cnt = 2'd2;
                nxt      = EXP_4OF4;
            end
            EXP_4OF4: held_cnt = 2'd3;
            default: held_cnt = 2'd0;
        endcase
    end

    assign cont_ok = (held_cnt != 2'd0) && is_oct && (oc >= lo) && (oc <= hi);

    always_comb
    begin
        lead = EXP_NONE;
        if (is_oct)
        begin
            if (oc inside {[8'hC2:8'hDF]})
                lead = EXP_2OF2;
            else if (oc == 8'hE0)
                lead = EXP_E0;
            else if (oc == 8'hED)
                lead = EXP_ED;
            else if (oc inside {[8'hE1:8'hEF]})
                lead = EXP_3B;
            else if (oc == 8'hF0)
                lead = EXP_F0;
            else if (oc == 8'hF4)
                lead = EXP_F4;
            else if (oc inside {[8'hF1:8'hF3]})
                lead = EXP_4B;
        end
    end

    always_comb
    begin
        case (held_cnt)
            2'd1:    cp = {10'd0, held_reg[4:0], oc[5:0]};
            2'd2:    cp = {5'd0, held_reg[11:8], held_reg[5:0], oc[5:0]};
            default: cp = {held_reg[18:16], held_reg[13:8], held_reg[5:0], oc[5:0]};
        endcase
    end

    // Next state and burst for the item at the input
    always_comb
    begin
        exp_next     = EXP_NONE;
        held_next    = 24'd0;
        b_oct_next   = {8'd0, held_reg};
        b_cnt_next   = {1'b0, held_cnt};
        b_sep_next   = raw;
        b_kind_next  = KIND_PLAIN;
        b_val_next   = {5'd0, token};
        b_bytes_next = 3'd0;
        tcnt_next    = 2'd0;
        if (cont_ok && nxt != EXP_NONE)
        begin
            exp_next   = nxt;
            held_next  = {held_reg[15:0], oc};
            b_cnt_next = 3'd0;
        end
        else if (cont_ok)
        begin
            if (raw)
            begin
                b_oct_next  = {held_reg, oc};
                b_cnt_next  = {1'b0, held_cnt} + 3'd1;
                b_sep_next  = 1'b0;
                b_kind_next = KIND_SEP;
                b_val_next  = SEP_TOKEN;
                tcnt_next   = 2'd1;
            end
            else
            begin
                b_cnt_next   = 3'd0;
                b_kind_next  = KIND_POINT;
                b_val_next   = cp;
                b_bytes_next = {1'b0, held_cnt} + 3'd1;
                tcnt_next    = 2'd1;
            end
        end
        else
        begin
            // held octets (if any) are flushed, then the token is handled afresh
            if (token == TOKEN_END)
                tcnt_next = 2'd1;
            else if (is_oct && !oc[7])
            begin
                case (form_reg)
                    FORM_RAW:   tcnt_next = 2'd2;
                    FORM_ASCII: tcnt_next = 2'd1;
                    default:
                    begin
                        b_kind_next  = KIND_POINT;
                        b_val_next   = {13'd0, oc};
                        b_bytes_next = 3'd1;
                        tcnt_next    = 2'd1;
                    end
                endcase
            end
            else if (lead != EXP_NONE)
            begin
                exp_next  = lead;
                held_next = {16'd0, oc};
            end
            else
                tcnt_next = raw ? 2'd2 : 2'd1;
        end
        b_flen_next  = b_sep_next ? {b_cnt_next, 1'b0} : {1'b0, b_cnt_next};
        b_total_next = b_flen_next + {2'd0, tcnt_next};
    end

    assign is_last   = ({1'b0, idx_reg} + 4'd1) == b_total_reg;
    assign out_valid = busy_reg;
    assign out_fire  = busy_reg && !out_stall;
    assign in_stall  = busy_reg && !(out_fire && is_last);
    assign in_fire   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            form_reg <= FORM_RESET;
            exp_reg  <= EXP_NONE;
            held_reg <= 24'd0;
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            if (cfg_wr_en)
                form_reg <= cfg_wr_data;
            if (in_fire)
            begin
                exp_reg  <= exp_next;
                held_reg <= held_next;
                busy_reg <= (b_total_next != 4'd0);
                idx_reg  <= 3'd0;
            end
            else if (out_fire)
            begin
                if (is_last)
                begin
                    busy_reg <= 1'b0;
                    idx_reg  <= 3'd0;
                end
                else
                    idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            b_oct_reg   <= b_oct_next;
            b_cnt_reg   <= b_cnt_next;
            b_sep_reg   <= b_sep_next;
            b_flen_reg  <= b_flen_next;
            b_kind_reg  <= b_kind_next;
            b_val_reg   <= b_val_next;
            b_bytes_reg <= b_bytes_next;
            b_total_reg <= b_total_next;
        end
    end

    // Result selection for the current burst position
    logic [1:0] j, sel;
    logic [2:0] cm1;
    logic [3:0] t;
    logic [7:0] octet;

    always_comb
    begin
        j   = b_sep_reg ? idx_reg[2:1] : idx_reg[1:0];
        cm1 = b_cnt_reg - 3'd1;
        sel = cm1[1:0] - j;   // oldest octet sits highest
        case (sel)
            2'd0:    octet = b_oct_reg[7:0];
            2'd1:    octet = b_oct_reg[15:8];
            2'd2:    octet = b_oct_reg[23:16];
            default: octet = b_oct_reg[31:24];
        endcase
        t          = {1'b0, idx_reg} - b_flen_reg;
        kind       = KIND_SEP;
        value      = SEP_TOKEN;
        byte_count = 3'd0;
        if ({1'b0, idx_reg} < b_flen_reg)
        begin
            if (!(b_sep_reg && idx_reg[0]))
            begin
                kind  = KIND_PLAIN;
                value = {13'd0, octet} + 21'd2;
            end
        end
        else if (t == 4'd0)
        begin
            kind       = b_kind_reg;
            value      = b_val_reg;
            byte_count = b_bytes_reg;
        end
        last = is_last;
    end

endmodule

`default_nettype wire

>>> design/u8sg_checker.sv
`default_nettype none

module u8sg_checker
    import u8sg_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  kind,
    input wire logic [20:0] value,
    input wire logic [2:0]  byte_count,
    input wire logic        last
);

    // input only backs up while a burst is still being delivered
    a_stall_needs_burst: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value)
            && $stable(byte_count) && $stable(last))
        else $error("stalled result changed");

    a_sep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SEP |-> value == SEP_TOKEN && byte_count == 3'd0)
        else $error("bad separator result");

    a_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_POINT |-> byte_count != 3'd0 && byte_count <= 3'd4
            && value <= MAX_CP && last)
        else $error("bad code point result");

    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("burst ended without last");

endmodule

bind utf8_sequence_grouper u8sg_checker u_u8sg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value      (value),
    .byte_count (byte_count),
    .last       (last)
);

`default_nettype wire

>>> sim/utf8_sequence_grouper_test.sv
`default_nettype none

module utf8_sequence_grouper_test;
    import u8sg_pkg::*;

    // Selector value 3 is unused and decodes like FORM_CP
    localparam logic [1:0]  FORM_ALT    = 2'd3;
    localparam int          SETTLE      = 4;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          PHASE_ITEMS = 50;

    typedef struct packed {
        kind_t       kind;
        logic [20:0] value;
        logic [2:0]  nbytes;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [15:0] tok;
        logic        fixed;
        kind_t       kind;
        logic [20:0] value;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] token = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [20:0] value;
    logic [2:0]  byte_count;
    logic        last;

    // Decoder state mirrored by the predictor
    logic [1:0]  form_now = FORM_RESET;
    exp_t        pend_st = EXP_NONE;
    logic [23:0] held = 24'd0;

    res_t        decoded_q[$];
    int          mismatches = 0;
    int          fed = 0;
    int          sink_hold = 0;
    int          quiet = 0;
    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;

    // Fixed rows assume the reset form (ASCII passes as its token)
    dir_row_t dir_rows [23] = '{
        '{16'd0,                  1'b1, KIND_PLAIN, 21'd0},
        '{16'hFFFF,               1'b1, KIND_PLAIN, 21'd65535},
        '{TOKEN_END,              1'b1, KIND_PLAIN, 21'd1},
        '{TOKEN_OCT_MIN,          1'b1, KIND_PLAIN, 21'd2},
        '{TOKEN_OCT_MIN + 16'h7F, 1'b1, KIND_PLAIN, 21'd129},
        '{TOKEN_OCT_MIN + 16'h80, 1'b1, KIND_PLAIN, 21'd130},   // stray continuation
        '{TOKEN_OCT_MAX,          1'b1, KIND_PLAIN, 21'd257},   // never a lead
        '{TOKEN_OCT_MIN + 16'hDF, 1'b0, KIND_PLAIN, 21'd0},
        '{TOKEN_OCT_MIN + 16'hBF, 1'b0, KIND_PLAIN, 21'd0},
        '{TOKEN_OCT_MIN + 16'hE0, 1'b0, KIND_PLAIN, 21'd0},
        '{TOKEN_OCT_MIN + 16'h9F, 1'b0, KIND_PLAIN, 21'd0},     // overlong, flush
        '{TOKEN_OCT_MIN + 16'hED, 1'b0, KIND_PLAIN, 21'd0},
        '{TOKEN_OCT_MIN + 16'hA0, 1'b0, KIND_PLAIN, 21'd0},     // surrogate, flush
        '{TOKEN_OCT_MIN + 16'hF4, 1'b0, KIND_PLAIN, 21'd0},
        '{TOKEN_OCT_MIN + 16'h8F, 1'b0, KIND_PLAIN, 21'd0},
        '{TOKEN_OCT_MIN + 16'hBF, 1'b0, KIND_PLAIN, 21'd0},
        '{TOKEN_OCT_MIN + 16'hBF, 1'b0, KIND_PLAIN, 21'd0},     // U+10FFFF
        '{TOKEN_OCT_MIN + 16'hF0, 1'b0, KIND_PLAIN, 21'd0},
        '{TOKEN_OCT_MIN + 16'h90, 1'b0, KIND_PLAIN, 21'd0},
        '{TOKEN_OCT_MIN + 16'h80, 1'b0, KIND_PLAIN, 21'd0},
        '{TOKEN_END,              1'b0, KIND_PLAIN, 21'd0},     // flush three held
        '{TOKEN_OCT_MIN + 16'hC2, 1'b0, KIND_PLAIN, 21'd0},
        '{16'hFFFF,               1'b0, KIND_PLAIN, 21'd0}      // non-octet breaks it
    };

    utf8_sequence_grouper u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .token       (token),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .value       (value),
        .byte_count  (byte_count),
        .last        (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [15:0] otok(input logic [7:0] b);
        return {8'd0, b} + TOKEN_OCT_MIN;
    endfunction

    function automatic void emit(ref res_t rq[$], input kind_t k, input logic [20:0] v,
                                 input logic [2:0] nb);
        res_t r;
        r.kind   = k;
        r.value  = v;
        r.nbytes = nb;
        r.last   = 1'b0;
        rq.push_back(r);
    endfunction

    function automatic void decode_token(input logic [15:0] tok, ref res_t rq[$]);
        logic        is_oct;
        logic [7:0]  oc;
        logic        raw;
        int          nheld;
        logic [7:0]  lo;
        logic [7:0]  hi;
        exp_t        nxt;
        logic [20:0] cp;
        is_oct = tok >= TOKEN_OCT_MIN && tok <= TOKEN_OCT_MAX;
        oc     = is_oct ? 8'(tok - TOKEN_OCT_MIN) : 8'h00;
        raw    = form_now == FORM_RAW;
        nheld  = 0;
        lo     = 8'h80;
        hi     = 8'hBF;
        nxt    = EXP_NONE;
        case (pend_st)
            EXP_2OF2: nheld = 1;
            EXP_E0:
            begin
                nheld = 1;
                lo    = 8'hA0;
                nxt   = EXP_3OF3;
            end
            EXP_ED:
            begin
                nheld = 1;
                hi    = 8'h9F;
                nxt   = EXP_3OF3;
            end
            EXP_3B:
            begin
                nheld = 1;
                nxt   = EXP_3OF3;
            end
            EXP_3OF3: nheld = 2;
            EXP_F0:
            begin
                nheld = 1;
                lo    = 8'h90;
                nxt   = EXP_3OF4;
            end
            EXP_F4:
            begin
                nheld = 1;
                hi    = 8'h8F;
                nxt   = EXP_3OF4;
            end
            EXP_4B:
            begin
                nheld = 1;
                nxt   = EXP_3OF4;
            end
            EXP_3OF4:
            begin
                nheld = 2;
                nxt   = EXP_4OF4;
            end
            EXP_4OF4: nheld = 3;
            default:  nheld = 0;
        endcase

        if (nheld > 0)
        begin
            if (is_oct && oc >= lo && oc <= hi)
            begin
                if (nxt != EXP_NONE)
                begin
                    held    = {held[15:0], oc};
                    pend_st = nxt;
                    return;
                end
                if (raw)
                begin
                    for (int i = nheld - 1; i >= 0; i--)
                        emit(rq, KIND_PLAIN, {13'd0, held[8*i +: 8]} + 21'd2, 3'd0);
                    emit(rq, KIND_PLAIN, {5'd0, tok}, 3'd0);
                    emit(rq, KIND_SEP, SEP_TOKEN, 3'd0);
                end
                else
                begin
                    case (nheld)
                        1:       cp = {10'd0, held[4:0], oc[5:0]};
                        2:       cp = {5'd0, held[11:8], held[5:0], oc[5:0]};
                        default: cp = {held[18:16], held[13:8], held[5:0], oc[5:0]};
                    endcase
                    emit(rq, KIND_POINT, cp, 3'(nheld + 1));
                end
                pend_st = EXP_NONE;
                held    = 24'd0;
                rq[rq.size() - 1].last = 1'b1;
                return;
            end
            // bad continuation: flush held octets, then treat tok as fresh
            for (int i = nheld - 1; i >= 0; i--)
            begin
                emit(rq, KIND_PLAIN, {13'd0, held[8*i +: 8]} + 21'd2, 3'd0);
                if (raw)
                    emit(rq, KIND_SEP, SEP_TOKEN, 3'd0);
            end
        end

        pend_st = EXP_NONE;
        held    = 24'd0;

        if (tok == TOKEN_END)
            emit(rq, KIND_PLAIN, {5'd0, tok}, 3'd0);
        else if (is_oct && oc <= 8'h7F)
        begin
            case (form_now)
                FORM_RAW:
                begin
                    emit(rq, KIND_PLAIN, {5'd0, tok}, 3'd0);
                    emit(rq, KIND_SEP, SEP_TOKEN, 3'd0);
                end
                FORM_ASCII: emit(rq, KIND_PLAIN, {5'd0, tok}, 3'd0);
                default:    emit(rq, KIND_POINT, {13'd0, oc}, 3'd1);
            endcase
        end
        else
        begin
            if (is_oct && oc >= 8'hC2 && oc <= 8'hDF)      pend_st = EXP_2OF2;
            else if (is_oct && oc == 8'hE0)                pend_st = EXP_E0;
            else if (is_oct && oc == 8'hED)                pend_st = EXP_ED;
            else if (is_oct && oc >= 8'hE1 && oc <= 8'hEF) pend_st = EXP_3B;
            else if (is_oct && oc == 8'hF0)                pend_st = EXP_F0;
            else if (is_oct && oc == 8'hF4)                pend_st = EXP_F4;
            else if (is_oct && oc >= 8'hF1 && oc <= 8'hF3) pend_st = EXP_4B;

            if (pend_st != EXP_NONE)
                held = {16'd0, oc};
            else
            begin
                emit(rq, KIND_PLAIN, {5'd0, tok}, 3'd0);
                if (raw)
                    emit(rq, KIND_SEP, SEP_TOKEN, 3'd0);
            end
        end

        if (rq.size() > 0)
            rq[rq.size() - 1].last = 1'b1;
    endfunction

    // Offer one token, wait for it to be taken, then queue what it decodes to
    task automatic feed(input logic [15:0] t, input bit use_row, input res_t row_res);
        int   gap;
        res_t rq[$];
        gap = src_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        token    <= t;
        do @(posedge clk); while (in_stall !== 1'b0);
        decode_token(t, rq);
        if (use_row)
            decoded_q.push_back(row_res);
        else
            foreach (rq[j])
                decoded_q.push_back(rq[j]);
        fed++;
    endtask

    task automatic feed_octet(input logic [7:0] b);
        feed(otok(b), 1'b0, '0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (decoded_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_form(input logic [1:0] f);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= f;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        form_now  = f;
    endtask

    // One random group: mostly well-formed sequences, some cut short, some noise
    task automatic send_group();
        logic [7:0]  seq[$];
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  b;
        logic [15:0] bad;
        int          len;
        int          sel;
        int          pick;
        int          cut;
        lo   = 8'h80;
        hi   = 8'hBF;
        len  = $urandom_range(1, 4);
        sel  = $urandom_range(0, 2);
        pick = $urandom_range(0, 99);
        case (len)
            1: seq.push_back(8'($urandom_range(0, 8'h7F)));
            2: seq.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            3:
            begin
                if (sel == 0)
                begin
                    seq.push_back(8'hE0);
                    lo = 8'hA0;
                end
                else if (sel == 1)
                begin
                    seq.push_back(8'hED);
                    hi = 8'h9F;
                end
                else
                begin
                    b = 8'($urandom_range(8'hE1, 8'hEF));
                    seq.push_back(b == 8'hED ? 8'hEE : b);
                end
            end
            default:
            begin
                if (sel == 0)
                begin
                    seq.push_back(8'hF0);
                    lo = 8'h90;
                end
                else if (sel == 1)
                begin
                    seq.push_back(8'hF4);
                    hi = 8'h8F;
                end
                else
                    seq.push_back(8'($urandom_range(8'hF1, 8'hF3)));
            end
        endcase
        if (len > 1)
            seq.push_back(8'($urandom_range(lo, hi)));
        while (seq.size() < len)
            seq.push_back(8'($urandom_range(8'h80, 8'hBF)));

        if (pick < 62)
        begin
            foreach (seq[i])
                feed_octet(seq[i]);
        end
        else if (pick < 80)
        begin
            cut = (len > 1) ? $urandom_range(1, len - 1) : 0;
            for (int i = 0; i < cut; i++)
                feed_octet(seq[i]);
            case ($urandom_range(0, 4))
                0:       bad = 16'($urandom_range(0, 16'hFFFF));
                1:       bad = TOKEN_END;
                2:       bad = otok(8'($urandom_range(0, 8'h7F)));
                3:       bad = otok(8'($urandom_range(8'hC0, 8'hFF)));
                default: bad = otok(8'($urandom_range(0, 8'hFF)));
            endcase
            feed(bad, 1'b0, '0);
        end
        else if (pick < 88)
            feed(TOKEN_END, 1'b0, '0);
        else if (pick < 94)
            feed(16'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
        else
            feed_octet(8'($urandom_range(0, 8'hFF)));
    endtask

    // Result side: check each item taken, then draw the stall before the next one
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected result kind %0d value %0d bytes %0d last %0d",
                             $time, kind, value, byte_count, last);
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (kind !== want.kind || value !== want.value ||
                        byte_count !== want.nbytes || last !== want.last)
                    begin
                        $display("%0t: expected kind %0d value %0d bytes %0d last %0d",
                                 $time, want.kind, want.value, want.nbytes, want.last);
                        $display("%0t:   actual kind %0d value %0d bytes %0d last %0d",
                                 $time, kind, value, byte_count, last);
                        mismatches++;
                    end
                end
                sink_hold = sink_idle ? $urandom_range(0, 4) : 0;
            end
            if (sink_hold > 0)
            begin
                out_stall <= 1'b1;
                sink_hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet == QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [1:0] forms [6];
        res_t       row_res;
        forms = '{FORM_RAW, FORM_CP, FORM_ALT, FORM_RAW, FORM_ASCII, FORM_CP};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row_res.kind   = dir_rows[i].kind;
            row_res.value  = dir_rows[i].value;
            row_res.nbytes = 3'd0;
            row_res.last   = 1'b1;
            feed(dir_rows[i].tok, dir_rows[i].fixed, row_res);
        end

        foreach (forms[ph])
        begin
            set_form(forms[ph]);
            src_idle  = (ph != 2);
            sink_idle = (ph != 2) && (ph != 4);
            while (fed < $size(dir_rows) + (ph + 1) * PHASE_ITEMS)
                send_group();
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
